[rtl/core/fsp_pkg.sv]
// shared types and constants for the frame sequence player
// no dependencies
package fsp_pkg;

  localparam int OP_W = 3;
  localparam logic [OP_W-1:0] OP_TICK       = 3'd0;
  localparam logic [OP_W-1:0] OP_PLAY       = 3'd1;
  localparam logic [OP_W-1:0] OP_PAUSE      = 3'd2;
  localparam logic [OP_W-1:0] OP_STOP       = 3'd3;
  localparam logic [OP_W-1:0] OP_SEEK       = 3'd4;
  localparam logic [OP_W-1:0] OP_LOAD_FRAME = 3'd5;
  localparam logic [OP_W-1:0] OP_LOAD_EVENT = 3'd6;

  localparam int REG_FRAME_COUNT = 0;
  localparam int REG_EVENT_COUNT = 1;
  localparam int REG_LOOP_ENABLE = 2;

  // controller commands to the datapath
  typedef struct packed {
    logic apply_op;    // execute non-tick operation
    logic tick_load;   // register scaled step
    logic tick_add;    // add step, advance frame
    logic sum_clear;   // start window sum
    logic sum_step;    // add one duration to window start
    logic ev_clear;    // start event scan
    logic ev_step;     // check one event
    logic emit_event;  // present event word
    logic emit_status; // present status word
  } fsp_cmd_t;

  // datapath status to the controller
  typedef struct packed {
    logic tick_active; // playing and frames in use
    logic sum_done;    // window start complete
    logic ev_done;     // all events scanned
    logic ev_hit;      // current event fires
  } fsp_stat_t;

endpackage

[rtl/core/frame_sequence_player_unit.sv]
// frame sequence player: one item at a time through a multi-cycle sequence.
// sequence: a non-tick item is applied on accept, then its status word is registered;
// a tick registers the scaled step and, if active, adds it, walks the window start,
// scans the events in use and registers one word per fired event, then the status word.
// a new item is accepted only after the status word; result words wait while out_ready is low.
// reset: synchronous, clears playback state, counts and fired flags; tables undefined.
module frame_sequence_player_unit import fsp_pkg::*; #(
  parameter int MAX_FRAMES = 16,
  parameter int MAX_EVENTS = 8,
  parameter int TIME_BITS  = 24
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  operation,
  input  logic [15:0] delta_time,
  input  logic [3:0]  entry_index,
  input  logic [23:0] frame_duration,
  input  logic [11:0] speed_factor,
  input  logic [27:0] trigger_time,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  frame_index,
  output logic [24:0] frame_elapsed,
  output logic        is_playing,
  output logic        is_finished,
  output logic        event_fired,
  output logic [2:0]  event_number,
  output logic        last_result,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  fsp_cmd_t  cmd;
  fsp_stat_t stat;
  logic      out_busy, cfg_we;
  logic [31:0] rd_fc, rd_ec, rd_le;

  // register port
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;
  always_comb begin
    case (paddr[3:2])
      2'(REG_FRAME_COUNT): prdata = rd_fc;
      2'(REG_EVENT_COUNT): prdata = rd_ec;
      2'(REG_LOOP_ENABLE): prdata = rd_le;
      default:             prdata = 32'd0;
    endcase
  end

  fsp_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .op(operation), .out_busy(out_busy), .stat(stat), .cmd(cmd)
  );

  fsp_datapath #(
    .MAX_FRAMES(MAX_FRAMES), .MAX_EVENTS(MAX_EVENTS), .TIME_BITS(TIME_BITS)
  ) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat),
    .operation(operation), .delta_time(delta_time), .entry_index(entry_index),
    .frame_duration(frame_duration), .speed_factor(speed_factor),
    .trigger_time(trigger_time),
    .cfg_we(cfg_we), .cfg_index(paddr[3:2]), .cfg_data(pwdata),
    .cfg_rdata_fc(rd_fc), .cfg_rdata_ec(rd_ec), .cfg_rdata_le(rd_le),
    .out_busy(out_busy), .out_valid(out_valid), .out_ready(out_ready),
    .frame_index(frame_index), .frame_elapsed(frame_elapsed),
    .is_playing(is_playing), .is_finished(is_finished),
    .event_fired(event_fired), .event_number(event_number),
    .last_result(last_result)
  );

  // a fired-event word never closes an item
  a_fire_not_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && event_fired |-> !last_result) else $error("event word marked last");

  // no new item while an event word of the last item is pending
  a_ready_quiet: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !(out_valid && !last_result)) else $error("accept during item");

  // finished and playing never both set
  a_fin_play: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(is_playing && is_finished)) else $error("playing while finished");

endmodule

[rtl/core/fsp_ctrl.sv]
// controller state machine for the frame sequence player
// depends on fsp_pkg
module fsp_ctrl import fsp_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic [OP_W-1:0] op,
  input  logic           out_busy,
  input  fsp_stat_t      stat,
  output fsp_cmd_t       cmd
);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_MUL    = 7'b0000010,
    S_ADD    = 7'b0000100,
    S_SUM    = 7'b0001000,
    S_EV     = 7'b0010000,
    S_EMIT   = 7'b0100000,
    S_STATUS = 7'b1000000
  } state_t;

  state_t state, state_next;

  // next state and commands
  always_comb begin
    state_next = state;
    cmd = '0;
    in_ready = (state == S_IDLE);
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (op == OP_TICK) begin
            cmd.tick_load = 1'b1;
            state_next = S_MUL;
          end else begin
            cmd.apply_op = 1'b1;
            state_next = S_STATUS;
          end
        end
      end
      S_MUL: begin
        if (stat.tick_active) begin
          cmd.tick_add = 1'b1;
          cmd.sum_clear = 1'b1;
          state_next = S_ADD;
        end else begin
          state_next = S_STATUS;
        end
      end
      S_ADD: state_next = S_SUM;
      S_SUM: begin
        if (stat.sum_done) begin
          cmd.ev_clear = 1'b1;
          state_next = S_EV;
        end else begin
          cmd.sum_step = 1'b1;
        end
      end
      S_EV: begin
        if (stat.ev_done) begin
          state_next = S_STATUS;
        end else if (stat.ev_hit) begin
          state_next = S_EMIT;
        end else begin
          cmd.ev_step = 1'b1;
        end
      end
      S_EMIT: begin
        if (!out_busy) begin
          cmd.emit_event = 1'b1;
          cmd.ev_step = 1'b1;
          state_next = S_EV;
        end
      end
      S_STATUS: begin
        if (!out_busy) begin
          cmd.emit_status = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

[rtl/core/fsp_datapath.sv]
// tables, timing state and result register of the frame sequence player
// depends on fsp_pkg
module fsp_datapath import fsp_pkg::*; #(
  parameter int MAX_FRAMES = 16,
  parameter int MAX_EVENTS = 8,
  parameter int TIME_BITS  = 24
) (
  input  logic                 clk,
  input  logic                 rst,
  input  fsp_cmd_t             cmd,
  output fsp_stat_t            stat,
  input  logic [OP_W-1:0]      operation,
  input  logic [15:0]          delta_time,
  input  logic [3:0]           entry_index,
  input  logic [23:0]          frame_duration,
  input  logic [11:0]          speed_factor,
  input  logic [27:0]          trigger_time,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_index,
  input  logic [31:0]          cfg_data,
  output logic [31:0]          cfg_rdata_fc,
  output logic [31:0]          cfg_rdata_ec,
  output logic [31:0]          cfg_rdata_le,
  output logic                 out_busy,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [3:0]           frame_index,
  output logic [24:0]          frame_elapsed,
  output logic                 is_playing,
  output logic                 is_finished,
  output logic                 event_fired,
  output logic [2:0]           event_number,
  output logic                 last_result
);

  localparam int FW  = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int FCW = $clog2(MAX_FRAMES + 1);
  localparam int EW  = (MAX_EVENTS > 1) ? $clog2(MAX_EVENTS) : 1;
  localparam int ECW = $clog2(MAX_EVENTS + 1);
  localparam int ET  = TIME_BITS + 1;
  localparam int SW  = TIME_BITS + FW + 1;
  localparam logic [ET-1:0] EMAX = {ET{1'b1}};

  logic [TIME_BITS-1:0] dur_mem [MAX_FRAMES];
  logic [11:0]          spd_mem [MAX_FRAMES];
  logic [27:0]          evt_mem [MAX_EVENTS];
  logic [MAX_EVENTS-1:0] done;

  logic [FW-1:0]  cur;
  logic [ET-1:0]  elapsed;
  logic           playing, finished, loop_en;
  logic [FCW-1:0] frame_cnt;
  logic [ECW-1:0] event_cnt;

  logic [27:0]    step;
  logic [FCW-1:0] sum_idx;
  logic [SW-1:0]  win_start;
  logic [ECW-1:0] ev_idx;

  // config values clamped to the table depth
  logic [FCW-1:0] fc_new;
  logic [ECW-1:0] ec_new;
  always_comb begin
    fc_new = (32'(cfg_data[4:0]) > MAX_FRAMES) ? FCW'(MAX_FRAMES) : FCW'(cfg_data[4:0]);
    ec_new = (32'(cfg_data[3:0]) > MAX_EVENTS) ? ECW'(MAX_EVENTS) : ECW'(cfg_data[3:0]);
  end

  // tick arithmetic on the current frame
  logic [TIME_BITS-1:0] cur_dur, last_dur;
  logic [ET:0]          sum_raw;
  logic [ET-1:0]        e_sat;
  logic [FCW-1:0]       cur_p1, last_f;
  always_comb begin
    cur_dur  = dur_mem[cur];
    last_f   = frame_cnt - FCW'(1);
    last_dur = dur_mem[last_f[FW-1:0]];
    sum_raw  = {1'b0, elapsed} + (ET+1)'(step);
    e_sat    = sum_raw[ET] ? EMAX : sum_raw[ET-1:0];
    cur_p1   = FCW'(cur) + FCW'(1);
  end

  // event window check
  logic [SW-1:0] win_end, t_ext;
  logic          ev_in;
  always_comb begin
    win_end = win_start + SW'(cur_dur);
    t_ext   = SW'(evt_mem[ev_idx[EW-1:0]]);
    ev_in   = (t_ext >= win_start) && (t_ext < win_end) &&
              (SW'(elapsed) >= t_ext - win_start);
    stat.tick_active = playing && (frame_cnt != '0);
    stat.sum_done    = (sum_idx == FCW'(cur));
    stat.ev_done     = (ev_idx >= event_cnt);
    stat.ev_hit      = !stat.ev_done && !done[ev_idx[EW-1:0]] && ev_in;
  end

  // table writes
  always_ff @(posedge clk) begin
    if (cmd.apply_op && operation == OP_LOAD_FRAME && 32'(entry_index) < MAX_FRAMES) begin
      dur_mem[entry_index[FW-1:0]] <= (frame_duration[TIME_BITS-1:0] == '0) ?
                                       TIME_BITS'(1) : frame_duration[TIME_BITS-1:0];
      spd_mem[entry_index[FW-1:0]] <= (speed_factor < 12'd3) ? 12'd3 : speed_factor;
    end
    if (cmd.apply_op && operation == OP_LOAD_EVENT && 32'(entry_index) < MAX_EVENTS) begin
      evt_mem[entry_index[EW-1:0]] <= trigger_time;
    end
  end

  // scaled step, one multiply then register
  always_ff @(posedge clk) begin
    if (cmd.tick_load) begin
      step <= 28'((32'(delta_time) * 32'(spd_mem[cur])) >> 8);
    end
  end

  // window start walk and event scan counters
  always_ff @(posedge clk) begin
    if (cmd.sum_clear) begin
      sum_idx   <= '0;
      win_start <= '0;
    end else if (cmd.sum_step) begin
      sum_idx   <= sum_idx + FCW'(1);
      win_start <= win_start + SW'(dur_mem[sum_idx[FW-1:0]]);
    end
    if (cmd.ev_clear) begin
      ev_idx <= '0;
    end else if (cmd.ev_step) begin
      ev_idx <= ev_idx + ECW'(1);
    end
  end

  // playback state
  always_ff @(posedge clk) begin
    if (rst) begin
      cur <= '0; elapsed <= '0; playing <= 1'b0; finished <= 1'b0;
      loop_en <= 1'b1; frame_cnt <= '0; event_cnt <= '0; done <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          2'(REG_FRAME_COUNT): begin
            frame_cnt <= fc_new;
            if (FCW'(cur) >= fc_new) begin
              cur <= '0;
              elapsed <= '0;
            end
          end
          2'(REG_EVENT_COUNT): begin
            event_cnt <= ec_new;
            for (int i = 0; i < MAX_EVENTS; i++) begin
              if (ECW'(i) >= ec_new) done[i] <= 1'b0;
            end
          end
          2'(REG_LOOP_ENABLE): begin
            loop_en <= cfg_data[0];
            if (cfg_data[0]) finished <= 1'b0;
          end
          default: ;
        endcase
      end
      if (cmd.apply_op) begin
        case (operation)
          OP_PLAY: begin
            if (frame_cnt != '0) begin
              playing <= 1'b1;
              if (finished) begin
                cur <= '0; elapsed <= '0; finished <= 1'b0;
              end
            end
          end
          OP_PAUSE: playing <= 1'b0;
          OP_STOP: begin
            playing <= 1'b0; cur <= '0; elapsed <= '0; finished <= 1'b0;
          end
          OP_SEEK: begin
            if (32'(entry_index) < 32'(frame_cnt)) begin
              cur <= entry_index[FW-1:0];
              elapsed <= '0;
            end
          end
          OP_LOAD_EVENT: begin
            if (32'(entry_index) < MAX_EVENTS) done[entry_index[EW-1:0]] <= 1'b0;
          end
          default: ;
        endcase
      end
      if (cmd.tick_add) begin
        if (e_sat >= ET'(cur_dur)) begin
          if (cur_p1 < frame_cnt) begin
            cur <= cur_p1[FW-1:0];
            elapsed <= e_sat - ET'(cur_dur);
          end else if (loop_en) begin
            cur <= '0;
            elapsed <= e_sat - ET'(cur_dur);
          end else begin
            cur <= last_f[FW-1:0];
            elapsed <= ET'(last_dur);
            playing <= 1'b0;
            finished <= 1'b1;
          end
        end else begin
          elapsed <= e_sat;
        end
      end
      if (cmd.emit_event) done[ev_idx[EW-1:0]] <= 1'b1;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_event || cmd.emit_status) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_event || cmd.emit_status) begin
      frame_index   <= 4'(cur);
      frame_elapsed <= 25'(elapsed);
      is_playing    <= playing;
      is_finished   <= finished;
      event_fired   <= cmd.emit_event;
      event_number  <= cmd.emit_event ? 3'(ev_idx) : 3'd0;
      last_result   <= cmd.emit_status;
    end
  end

  assign out_busy     = out_valid && !out_ready;
  assign cfg_rdata_fc = 32'(frame_cnt);
  assign cfg_rdata_ec = 32'(event_cnt);
  assign cfg_rdata_le = 32'(loop_en);

endmodule

[test/frame_sequence_player_unit_tb.sv]
// self-checking testbench for frame_sequence_player_unit: random and directed command words,
// a predictor of the playback state and fired events, and an apb-style register writer
// depends on fsp_pkg and frame_sequence_player_unit
`timescale 1ns / 1ps

module frame_sequence_player_unit_tb import fsp_pkg::*; ();

  localparam int NFRAMES   = 16;
  localparam int NEVENTS   = 8;
  localparam int EMAX      = (1 << 25) - 1;
  localparam int LIMIT     = 600000;
  localparam int DRAIN     = 64;
  localparam logic [2:0] OP_UNKNOWN = 3'd7;

  typedef struct packed {
    logic [2:0]  op;
    logic [15:0] dt;
    logic [3:0]  idx;
    logic [23:0] dur;
    logic [11:0] spd;
    logic [27:0] trig;
  } cmd_t;

  typedef struct packed {
    logic [3:0]  frame;
    logic [24:0] elapsed;
    logic        playing;
    logic        finished;
    logic        fired;
    logic [2:0]  num;
    logic        last;
  } status_t;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic out_ready = 0;
  logic [2:0]  operation = '0;
  logic [15:0] delta_time = '0;
  logic [3:0]  entry_index = '0;
  logic [23:0] frame_duration = '0;
  logic [11:0] speed_factor = '0;
  logic [27:0] trigger_time = '0;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic in_ready, out_valid, pready;
  logic [3:0]  frame_index;
  logic [24:0] frame_elapsed;
  logic is_playing, is_finished, event_fired, last_result;
  logic [2:0]  event_number;
  logic [31:0] prdata;

  frame_sequence_player_unit DUT (.*);

  // predictor state
  logic [23:0] dur_tab [NFRAMES];
  logic [11:0] spd_tab [NFRAMES];
  logic [27:0] ev_time [NEVENTS];
  logic        ev_done [NEVENTS];
  logic [3:0]  cur_frame;
  logic [24:0] elapsed;
  logic        playing, finished;
  int          n_frames, n_events;
  logic        looping;

  cmd_t    cmd_queue [$];
  status_t status_queue [$];
  cmd_t    on_bus;
  int      errors = 0, n_words = 0, n_results = 0, n_fired = 0, cycles = 0;
  bit      calm = 0, hold_req = 0;
  int      hold_left = 0;

  initial forever #5 clk = ~clk;

  function automatic status_t snap(logic fired, logic [2:0] num, logic last);
    status_t s;
    s.frame = cur_frame; s.elapsed = elapsed; s.playing = playing;
    s.finished = finished; s.fired = fired; s.num = num; s.last = last;
    return s;
  endfunction

  // append an expected result word
  task automatic queue_result(input status_t s);
    status_queue = {status_queue, s};
  endtask

  // append a pending command word
  task automatic enqueue(input cmd_t c);
    cmd_queue = {cmd_queue, c};
  endtask

  // advance playback by one tick and queue fired events
  task automatic play_tick(input logic [15:0] dt);
    longint unsigned e, start, stop;
    int f;
    if (!playing || n_frames == 0) return;
    f = cur_frame;
    e = longint'(elapsed) + ((longint'(dt) * longint'(spd_tab[f])) >> 8);
    if (e > EMAX) e = EMAX;
    if (e >= dur_tab[f]) begin
      e -= dur_tab[f];
      if (f + 1 < n_frames) f++;
      else if (looping) f = 0;
      else begin
        f = n_frames - 1;
        e = dur_tab[f];
        playing = 0;
        finished = 1;
      end
    end
    cur_frame = 4'(f);
    elapsed = 25'(e);
    start = 0;
    for (int i = 0; i < f; i++) start += dur_tab[i];
    stop = start + dur_tab[f];
    for (int i = 0; i < n_events; i++) begin
      if (!ev_done[i] && ev_time[i] >= start && ev_time[i] < stop &&
          e >= ev_time[i] - start) begin
        ev_done[i] = 1;
        queue_result(snap(1, 3'(i), 0));
        n_fired++;
      end
    end
  endtask

  // compute expected results of one accepted command word
  task automatic predict_word(input cmd_t c);
    case (c.op)
      OP_TICK: play_tick(c.dt);
      OP_PLAY: if (n_frames != 0) begin
        playing = 1;
        if (finished) begin
          cur_frame = 0; elapsed = 0; finished = 0;
        end
      end
      OP_PAUSE: playing = 0;
      OP_STOP: begin
        playing = 0; cur_frame = 0; elapsed = 0; finished = 0;
      end
      OP_SEEK: if (c.idx < n_frames) begin
        cur_frame = c.idx; elapsed = 0;
      end
      OP_LOAD_FRAME: begin
        dur_tab[c.idx] = (c.dur == 0) ? 24'd1 : c.dur;
        spd_tab[c.idx] = (c.spd < 3) ? 12'd3 : c.spd;
      end
      OP_LOAD_EVENT: if (c.idx < NEVENTS) begin
        ev_time[c.idx] = c.trig;
        ev_done[c.idx] = 0;
      end
      default: ;
    endcase
    queue_result(snap(0, 0, 1));
  endtask

  task automatic report(input string what, input int got, input int want);
    $display("mismatch on %s: got %0d expected %0d (result %0d)", what, got, want, n_results);
    errors++;
  endtask

  // apb write: setup then access, mirrored into the predictor
  task automatic write_reg(input int index, input logic [31:0] value);
    @(posedge clk);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= 4'(4 * index); pwdata <= value;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    case (index)
      REG_FRAME_COUNT: begin
        n_frames = (value[4:0] > NFRAMES) ? NFRAMES : value[4:0];
        if (cur_frame >= n_frames) begin
          cur_frame = 0; elapsed = 0;
        end
      end
      REG_EVENT_COUNT: begin
        n_events = (value[3:0] > NEVENTS) ? NEVENTS : value[3:0];
        for (int i = n_events; i < NEVENTS; i++) ev_done[i] = 0;
      end
      REG_LOOP_ENABLE: begin
        looping = value[0];
        if (looping) finished = 0;
      end
      default: ;
    endcase
  endtask

  function automatic cmd_t make_cmd(input logic [2:0] op, input int idx);
    cmd_t c;
    c.op = op;
    c.idx = 4'(idx);
    c.dt = ($urandom_range(0, 9) < 7) ? 16'($urandom_range(0, 2000)) : 16'($urandom);
    case ($urandom_range(0, 9))
      0, 1:    c.dur = 24'($urandom);
      2, 3, 4: c.dur = 24'($urandom_range(0, 60000));
      default: c.dur = 24'($urandom_range(0, 3000));
    endcase
    c.spd = ($urandom_range(0, 3) == 0) ? 12'($urandom) : 12'($urandom_range(0, 800));
    c.trig = ($urandom_range(0, 3) == 0) ? 28'($urandom) : 28'($urandom_range(0, 30000));
    return c;
  endfunction

  // weighted random word, mostly ticks
  function automatic cmd_t random_cmd();
    int r;
    logic [2:0] op;
    r = $urandom_range(0, 99);
    if (r < 55) op = OP_TICK;
    else if (r < 66) op = OP_PLAY;
    else if (r < 70) op = OP_PAUSE;
    else if (r < 73) op = OP_STOP;
    else if (r < 81) op = OP_SEEK;
    else if (r < 88) op = OP_LOAD_FRAME;
    else if (r < 97) op = OP_LOAD_EVENT;
    else op = OP_UNKNOWN;
    return make_cmd(op, $urandom_range(0, 15));
  endfunction

  task automatic drain();
    while (cmd_queue.size() != 0 || in_valid || status_queue.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  // command driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 0;
    end else begin
      if (in_valid && in_ready) begin
        predict_word(on_bus);
        n_words++;
      end
      if (!in_valid || in_ready) begin
        if (cmd_queue.size() != 0 && (calm || $urandom_range(0, 99) >= 7)) begin
          on_bus = cmd_queue.pop_front();
          operation <= on_bus.op; delta_time <= on_bus.dt; entry_index <= on_bus.idx;
          frame_duration <= on_bus.dur; speed_factor <= on_bus.spd;
          trigger_time <= on_bus.trig;
          in_valid <= 1;
        end else begin
          in_valid <= 0;
        end
      end
    end
  end

  // result monitor with random and long back-pressure
  always @(posedge clk) begin
    status_t want;
    if (rst) begin
      out_ready <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (status_queue.size() == 0) begin
          $display("unexpected result word at cycle %0d", cycles);
          errors++;
        end else begin
          want = status_queue.pop_front();
          if (frame_index !== want.frame) report("frame_index", frame_index, want.frame);
          if (frame_elapsed !== want.elapsed)
            report("frame_elapsed", frame_elapsed, want.elapsed);
          if (is_playing !== want.playing) report("is_playing", is_playing, want.playing);
          if (is_finished !== want.finished)
            report("is_finished", is_finished, want.finished);
          if (event_fired !== want.fired) report("event_fired", event_fired, want.fired);
          if (event_number !== want.num) report("event_number", event_number, want.num);
          if (last_result !== want.last) report("last_result", last_result, want.last);
        end
        n_results++;
      end
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 0;
      end else if (hold_req) begin
        hold_req = 0;
        hold_left <= 300;
        out_ready <= 0;
      end else begin
        out_ready <= calm || ($urandom_range(0, 99) >= 7);
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    int fc [8] = '{16, 3, 1, 31, 0, 5, 16, 2};
    int ec [8] = '{8, 2, 8, 15, 0, 4, 8, 1};
    int lp [8] = '{1, 0, 0, 1, 1, 0, 0, 1};
    cmd_t c;
    for (int i = 0; i < NEVENTS; i++) ev_done[i] = 0;
    cur_frame = 0; elapsed = 0; playing = 0; finished = 0;
    n_frames = 0; n_events = 0; looping = 1;
    repeat (9) @(posedge clk);
    rst <= 0;

    // table setup: every frame and event entry written before any playback
    for (int i = 0; i < NFRAMES; i++) begin
      c = make_cmd(OP_LOAD_FRAME, i);
      c.dur = (i == 0) ? 24'd0 : (i == 15) ? 24'hffffff : 24'($urandom_range(1, 2000));
      c.spd = (i == 0) ? 12'd0 : (i == 1) ? 12'd3 : (i == 2) ? 12'hfff : 12'd256;
      enqueue(c);
    end
    for (int i = 0; i < NEVENTS; i++) begin
      c = make_cmd(OP_LOAD_EVENT, i);
      c.trig = (i == 0) ? 28'd0 : (i == 7) ? 28'hfffffff : 28'($urandom_range(0, 8000));
      enqueue(c);
    end
    drain();
    write_reg(REG_FRAME_COUNT, 16);
    write_reg(REG_EVENT_COUNT, 8);
    write_reg(REG_LOOP_ENABLE, 1);

    // directed corners
    enqueue(make_cmd(OP_LOAD_EVENT, 15));
    enqueue(make_cmd(OP_PLAY, 0));
    c = make_cmd(OP_TICK, 0); c.dt = 0; enqueue(c);
    c = make_cmd(OP_TICK, 0); c.dt = 16'hffff; enqueue(c);
    c = make_cmd(OP_TICK, 0); c.dt = 16'hffff; enqueue(c);
    enqueue(make_cmd(OP_PAUSE, 0));
    enqueue(make_cmd(OP_TICK, 0));
    enqueue(make_cmd(OP_SEEK, 15));
    enqueue(make_cmd(OP_PLAY, 0));
    c = make_cmd(OP_TICK, 0); c.dt = 16'hffff; enqueue(c);
    enqueue(make_cmd(OP_STOP, 0));
    enqueue(make_cmd(OP_UNKNOWN, 0));
    drain();

    // random phases across register settings
    for (int p = 0; p < 8; p++) begin
      write_reg(REG_FRAME_COUNT, fc[p]);
      write_reg(REG_EVENT_COUNT, ec[p]);
      write_reg(REG_LOOP_ENABLE, lp[p]);
      calm = (p == 2);
      enqueue(make_cmd(OP_PLAY, 0));
      for (int k = 0; k < 48; k++) enqueue(random_cmd());
      if (p == 5) hold_req = 1;
      drain();
    end
    calm = 0;

    $display("%0d command words and %0d result words checked, %0d events fired,",
             n_words, n_results, n_fired);
    $display("over eight register settings with loop and one-shot playback");
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
